// File: design/mme_pkg.sv
`default_nettype none

package mme_pkg;

  // default sizes
  localparam int MaxRoutes       = 64;
  localparam int MaxDestinations = 32;
  localparam int MaxMacros       = 8;
  localparam int MaxLfos         = 4;

  localparam int Q14One  = 16384;
  localparam int Q14Half = 8192;
  localparam int Q16One  = 65536;

  // item modes
  localparam logic [2:0] MODE_SET_SOURCE   = 3'd0;
  localparam logic [2:0] MODE_SET_BASE     = 3'd1;
  localparam logic [2:0] MODE_LOAD_DEST    = 3'd2;
  localparam logic [2:0] MODE_ADD_ROUTE    = 3'd3;
  localparam logic [2:0] MODE_REMOVE_ROUTE = 3'd4;
  localparam logic [2:0] MODE_EVALUATE     = 3'd5;

  // result status
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BUDGET_FULL = 3'd1;
  localparam logic [2:0] ST_BAD_SOURCE  = 3'd2;
  localparam logic [2:0] ST_BAD_DEPTH   = 3'd3;
  localparam logic [2:0] ST_BAD_DEST    = 3'd4;
  localparam logic [2:0] ST_DUPLICATE   = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX   = 3'd6;
  localparam logic [2:0] ST_BAD_DESC    = 3'd7;

  // source kinds
  localparam logic [3:0] KIND_MACRO = 4'd0;
  localparam logic [3:0] KIND_LFO   = 4'd1;
  localparam logic [3:0] KIND_FIRST_FIXED = 4'd2;
  localparam logic [3:0] KIND_LAST  = 4'd8;

  // destination types
  localparam logic [1:0] DTYPE_INTEGER = 2'd1;
  localparam logic [1:0] DTYPE_CHOICE  = 2'd2;
  localparam logic [1:0] DTYPE_BOOLEAN = 2'd3;

  // transforms
  localparam logic [1:0] XF_BIPOLAR = 2'd1;

  // configuration register indexes
  localparam logic CFG_ROUTE_BUDGET = 1'b0;
  localparam logic CFG_DEST_COUNT   = 1'b1;

  typedef struct packed {
    logic [3:0]         kind;
    logic [2:0]         index;
    logic               bipolar;
    logic signed [15:0] depth;
    logic [5:0]         dest;
  } route_t;

  localparam int RouteBits = $bits(route_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_DUP_RD,
    S_DUP_CMP,
    S_SH_RD,
    S_SH_CMP,
    S_RM_RD,
    S_RM_WR,
    S_EV_RD,
    S_EV_MUL,
    S_EV_ACC,
    S_DST_SCAN,
    S_DST_MUL,
    S_DST_PLAIN,
    S_DST_DIV,
    S_DST_EMIT,
    S_RESPOND
  } state_t;

endpackage

`default_nettype wire

// File: design/mme_ram.sv
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/mme_rem.sv
`default_nettype none

// restoring remainder, one dividend bit per cycle
module mme_rem #(
  parameter int DW = 34,
  parameter int QW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [QW-1:0] divisor,
  output logic               done,
  output logic      [QW-1:0] rem
);

  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]   shreg;
  logic [QW-1:0]   dsr;
  logic [CntW-1:0] cnt;
  logic [QW:0]     trial;

  assign trial = {rem, shreg[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CntW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (cnt != '0) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, dsr}) begin
        rem <= QW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[QW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/modulation_matrix_engine_core.sv
`default_nettype none

// Modulation matrix engine. Each input transaction carries one command (mode):
// set a source value, set a destination base, load a destination range, add
// a route, remove a route, or evaluate. Every command except evaluate answers
// with exactly one result transaction (status, last=1). Evaluate answers with
// one result per destination touched by a route, in destination order, last=1
// on the final one; with nothing touched it answers one empty result.
// Routes live in a single-port-read RAM kept sorted by destination, source
// kind and source index; every walk over it goes one entry at a time under a
// small sequencer, and the block is not ready while it runs. The quantizing
// remainder unit runs for a touched destination that has a step (or is
// integer/choice) and is not boolean; it works one dividend bit per cycle.
// Results sit in an output register so the next command is taken while the
// last result still waits for out_ready.
// Configuration: cfg_index 0 is the route budget (saturates at MAX_ROUTES,
// writing it empties the route table), 1 the destination count (saturates at
// MAX_DESTINATIONS). Write only while idle.
module modulation_matrix_engine_core #(
  parameter int MAX_ROUTES       = mme_pkg::MaxRoutes,
  parameter int MAX_DESTINATIONS = mme_pkg::MaxDestinations,
  parameter int MAX_MACROS       = mme_pkg::MaxMacros,
  parameter int MAX_LFOS         = mme_pkg::MaxLfos
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [6:0]         cfg_data,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         mode,
  input  wire logic [5:0]         slot,
  input  wire logic [3:0]         source_kind,
  input  wire logic [2:0]         source_index,
  input  wire logic [1:0]         transform,
  input  wire logic signed [15:0] value,
  input  wire logic               value_invalid,
  input  wire logic signed [31:0] dest_minimum,
  input  wire logic signed [31:0] dest_maximum,
  input  wire logic [30:0]        dest_step,
  input  wire logic [1:0]         dest_type,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic                    has_value,
  output logic [4:0]              dest_index,
  output logic [14:0]             normalized_out,
  output logic signed [31:0]      plain_out,
  output logic                    last
);

  localparam int RaW      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CntW     = $clog2(MAX_ROUTES + 1);
  localparam int DaW      = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
  localparam int DcW      = $clog2(MAX_DESTINATIONS + 1);
  localparam int SrcSlots = MAX_MACROS + MAX_LFOS + 7;
  localparam int SrcW     = $clog2(SrcSlots);
  localparam int CmpW     = (CntW > 7) ? CntW : 7;
  localparam int OffW     = 34;

  // {valid, slot} of a source
  function automatic logic [SrcW:0] source_sel(input logic [3:0] kind,
                                               input logic [2:0] idx);
    logic [SrcW:0] r;
    r = '0;
    if (kind == mme_pkg::KIND_MACRO) begin
      if (int'(idx) < MAX_MACROS) r = {1'b1, SrcW'(idx)};
    end else if (kind == mme_pkg::KIND_LFO) begin
      if (int'(idx) < MAX_LFOS) r = {1'b1, SrcW'(MAX_MACROS + int'(idx))};
    end else if (kind <= mme_pkg::KIND_LAST && idx == 3'd0) begin
      r = {1'b1, SrcW'(MAX_MACROS + MAX_LFOS + int'(kind)
                       - int'(mme_pkg::KIND_FIRST_FIXED))};
    end
    return r;
  endfunction

  mme_pkg::state_t state, state_next;

  // latched command
  logic [2:0]         cur_mode;
  logic [5:0]         cur_slot;
  logic [3:0]         cur_kind;
  logic [2:0]         cur_idx;
  logic [1:0]         cur_xf;
  logic signed [15:0] cur_value;
  logic               cur_bad;
  logic signed [31:0] cur_min;
  logic signed [31:0] cur_max;
  logic [30:0]        cur_step;
  logic [1:0]         cur_type;

  // control state
  logic [CntW-1:0] route_total;
  logic [CntW-1:0] budget;
  logic [DcW-1:0]  dest_count;
  logic [CntW-1:0] ptr;
  logic [DcW-1:0]  dptr;
  logic [2:0]      res_status;
  logic [MAX_DESTINATIONS-1:0] touched;

  // stores
  logic signed [15:0] source_store [SrcSlots];
  logic signed [15:0] base_store [MAX_DESTINATIONS];
  logic [MAX_DESTINATIONS-1:0] base_bad;
  logic signed [31:0] range_low_store [MAX_DESTINATIONS];
  logic signed [31:0] range_high_store [MAX_DESTINATIONS];
  logic [30:0]        step_store [MAX_DESTINATIONS];
  logic [1:0]         type_store [MAX_DESTINATIONS];
  logic signed [20:0] sum_store [MAX_DESTINATIONS];

  // evaluation datapath registers
  logic signed [32:0] ev_prod;
  logic               ev_skip;
  logic [DaW-1:0]     ev_dest;
  logic [14:0]        norm;
  logic [46:0]        span_prod;
  logic [OffW-1:0]    m_reg;
  logic signed [31:0] plain_val;

  // route RAM
  logic             ram_we;
  logic [RaW-1:0]   ram_waddr;
  logic [RaW-1:0]   ram_raddr;
  logic [mme_pkg::RouteBits-1:0] ram_wdata;
  logic [mme_pkg::RouteBits-1:0] ram_rdata;
  mme_pkg::route_t  rd_route;
  mme_pkg::route_t  new_route;

  mme_ram #(
    .WIDTH (mme_pkg::RouteBits),
    .DEPTH (MAX_ROUTES)
  ) u_route_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_route = mme_pkg::route_t'(ram_rdata);

  always_comb begin
    new_route.kind    = cur_kind;
    new_route.index   = cur_idx;
    new_route.bipolar = (cur_xf == mme_pkg::XF_BIPOLAR);
    new_route.depth   = cur_value;
    new_route.dest    = cur_slot;
  end

  // remainder unit for step quantization
  logic            rem_start;
  logic            rem_done;
  logic [30:0]     rem_val;
  logic [OffW-1:0] m_next;

  mme_rem #(
    .DW (OffW),
    .QW (31)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (m_next),
    .divisor  (quantum),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // ---------------- decode ----------------
  logic            out_free;
  logic [SrcW:0]   cur_src;
  logic            total_full;
  logic            depth_ok;
  logic            dest_bad;
  logic            slot_oob;
  logic            rm_bad;
  logic            is_dup;
  logic            ordered;
  logic            ptr_at_end;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == mme_pkg::S_IDLE);
  assign cur_src  = source_sel(cur_kind, cur_idx);
  assign total_full = CmpW'(route_total) >= CmpW'(budget);
  assign depth_ok = !cur_bad && (cur_value >= -16'sd16384) && (cur_value <= 16'sd16384);
  assign dest_bad = 7'(cur_slot) >= 7'(dest_count);
  assign slot_oob = int'(cur_slot) >= MAX_DESTINATIONS;
  assign rm_bad   = CmpW'(cur_slot) >= CmpW'(route_total);
  assign is_dup   = (rd_route.kind == cur_kind) && (rd_route.index == cur_idx) &&
                    (rd_route.dest == cur_slot);
  assign ordered  = (rd_route.dest < cur_slot) ||
                    ((rd_route.dest == cur_slot) &&
                     ((rd_route.kind < cur_kind) ||
                      ((rd_route.kind == cur_kind) && (rd_route.index <= cur_idx))));
  assign ptr_at_end = ptr >= route_total;

  // route contribution
  logic [SrcW:0]      rt_src;
  logic signed [16:0] sv, vc, vb;
  logic signed [33:0] rnd;

  assign rt_src = source_sel(rd_route.kind, rd_route.index);

  always_comb begin
    sv = rt_src[SrcW] ? 17'(source_store[rt_src[SrcW-1:0]]) : 17'sd0;
    if (rd_route.kind == mme_pkg::KIND_LFO) begin
      vc = (sv < -17'sd16384) ? -17'sd16384 : ((sv > 17'sd16384) ? 17'sd16384 : sv);
    end else begin
      vc = (sv < 17'sd0) ? 17'sd0 : ((sv > 17'sd16384) ? 17'sd16384 : sv);
    end
    if (rd_route.bipolar && rd_route.kind != mme_pkg::KIND_LFO) begin
      vb = (vc <<< 1) - 17'sd16384;
    end else begin
      vb = vc;
    end
  end

  // ties away from zero
  always_comb begin
    if (ev_prod >= 0) begin
      rnd = (34'(ev_prod) + 34'sd8192) >>> 14;
    end else begin
      rnd = -((-34'(ev_prod) + 34'sd8192) >>> 14);
    end
  end

  // destination datapath
  logic [DaW-1:0]     didx;
  logic               dptr_end;
  logic signed [21:0] nsum;
  logic [14:0]        norm_n;
  logic signed [31:0] d_lo, d_hi;
  logic [31:0]        span;
  logic [30:0]        quantum;
  logic [OffW-1:0]    off;
  logic signed [35:0] add_term;
  logic signed [35:0] plain_sum;
  logic signed [31:0] plain_clamped;
  logic               later_touched;

  assign didx     = dptr[DaW-1:0];
  assign dptr_end = 7'(dptr) >= 7'(dest_count);
  assign d_lo     = range_low_store[didx];
  assign d_hi     = range_high_store[didx];
  assign span     = 32'(33'(d_hi) - 33'(d_lo));

  always_comb begin
    nsum = 22'(base_store[didx]) + 22'(sum_store[didx]);
    if (base_bad[didx] || nsum < 22'sd0) begin
      norm_n = '0;
    end else if (nsum > 22'sd16384) begin
      norm_n = 15'(mme_pkg::Q14One);
    end else begin
      norm_n = nsum[14:0];
    end
  end

  always_comb begin
    if (step_store[didx] != '0) begin
      quantum = step_store[didx];
    end else if (type_store[didx] == mme_pkg::DTYPE_INTEGER ||
                 type_store[didx] == mme_pkg::DTYPE_CHOICE) begin
      quantum = 31'(mme_pkg::Q16One);
    end else begin
      quantum = '0;
    end
  end

  assign off    = OffW'((span_prod + 47'(mme_pkg::Q14Half)) >> 14);
  assign m_next = off + OffW'(quantum >> 1);

  always_comb begin
    if (state == mme_pkg::S_DST_DIV) begin
      add_term = 36'(m_reg) - 36'(rem_val);
    end else begin
      add_term = 36'(off);
    end
    plain_sum = 36'(d_lo) + add_term;
    plain_clamped = (plain_sum > 36'(d_hi)) ? d_hi : plain_sum[31:0];
  end

  always_comb begin
    later_touched = 1'b0;
    for (int j = 0; j < MAX_DESTINATIONS; j++) begin
      if (touched[j] && j > int'(dptr)) later_touched = 1'b1;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = ptr[RaW-1:0];
    ram_wdata  = new_route;
    ram_raddr  = ptr[RaW-1:0];
    rem_start  = 1'b0;
    unique case (state)
      mme_pkg::S_IDLE: begin
        if (in_valid) state_next = mme_pkg::S_DISPATCH;
      end
      mme_pkg::S_DISPATCH: begin
        state_next = mme_pkg::S_RESPOND;
        if (cur_mode == mme_pkg::MODE_ADD_ROUTE) begin
          if (!total_full && cur_src[SrcW] && cur_xf <= mme_pkg::XF_BIPOLAR &&
              depth_ok && !dest_bad) begin
            state_next = (route_total == '0) ? mme_pkg::S_SH_RD : mme_pkg::S_DUP_RD;
          end
        end else if (cur_mode == mme_pkg::MODE_REMOVE_ROUTE) begin
          if (!rm_bad) state_next = mme_pkg::S_RM_RD;
        end else if (cur_mode == mme_pkg::MODE_EVALUATE) begin
          state_next = mme_pkg::S_EV_RD;
        end
      end
      mme_pkg::S_DUP_RD: begin
        state_next = mme_pkg::S_DUP_CMP;
      end
      mme_pkg::S_DUP_CMP: begin
        if (is_dup) begin
          state_next = mme_pkg::S_RESPOND;
        end else if (ptr + 1'b1 == route_total) begin
          state_next = mme_pkg::S_SH_RD;
        end else begin
          state_next = mme_pkg::S_DUP_RD;
        end
      end
      mme_pkg::S_SH_RD: begin
        ram_raddr = RaW'(ptr - 1'b1);
        if (ptr == '0) begin
          ram_we     = 1'b1;
          state_next = mme_pkg::S_RESPOND;
        end else begin
          state_next = mme_pkg::S_SH_CMP;
        end
      end
      mme_pkg::S_SH_CMP: begin
        ram_we = 1'b1;
        if (ordered) begin
          state_next = mme_pkg::S_RESPOND;
        end else begin
          ram_wdata  = ram_rdata;
          state_next = mme_pkg::S_SH_RD;
        end
      end
      mme_pkg::S_RM_RD: begin
        state_next = ptr_at_end ? mme_pkg::S_RESPOND : mme_pkg::S_RM_WR;
      end
      mme_pkg::S_RM_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = RaW'(ptr - 1'b1);
        ram_wdata  = ram_rdata;
        state_next = mme_pkg::S_RM_RD;
      end
      mme_pkg::S_EV_RD: begin
        if (ptr_at_end) begin
          state_next = (touched == '0) ? mme_pkg::S_RESPOND : mme_pkg::S_DST_SCAN;
        end else begin
          state_next = mme_pkg::S_EV_MUL;
        end
      end
      mme_pkg::S_EV_MUL: begin
        state_next = mme_pkg::S_EV_ACC;
      end
      mme_pkg::S_EV_ACC: begin
        state_next = mme_pkg::S_EV_RD;
      end
      mme_pkg::S_DST_SCAN: begin
        if (dptr_end) begin
          state_next = mme_pkg::S_IDLE;
        end else if (touched[didx]) begin
          state_next = mme_pkg::S_DST_MUL;
        end
      end
      mme_pkg::S_DST_MUL: begin
        state_next = mme_pkg::S_DST_PLAIN;
      end
      mme_pkg::S_DST_PLAIN: begin
        if (type_store[didx] != mme_pkg::DTYPE_BOOLEAN && quantum != '0) begin
          rem_start  = 1'b1;
          state_next = mme_pkg::S_DST_DIV;
        end else begin
          state_next = mme_pkg::S_DST_EMIT;
        end
      end
      mme_pkg::S_DST_DIV: begin
        if (rem_done) state_next = mme_pkg::S_DST_EMIT;
      end
      mme_pkg::S_DST_EMIT: begin
        if (out_free) state_next = mme_pkg::S_DST_SCAN;
      end
      mme_pkg::S_RESPOND: begin
        if (out_free) state_next = mme_pkg::S_IDLE;
      end
      default: state_next = mme_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers and reset-cleared stores
  always_ff @(posedge clk) begin
    if (rst) begin
      route_total <= '0;
      budget      <= '0;
      dest_count  <= '0;
      ptr         <= '0;
      dptr        <= '0;
      res_status  <= mme_pkg::ST_OK;
      touched     <= '0;
      base_bad    <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < SrcSlots; i++) source_store[i] <= '0;
      for (int i = 0; i < MAX_DESTINATIONS; i++) base_store[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mme_pkg::CFG_ROUTE_BUDGET) begin
          budget      <= (int'(cfg_data) > MAX_ROUTES) ? CntW'(MAX_ROUTES) : CntW'(cfg_data);
          route_total <= '0;
        end else begin
          dest_count  <= (int'(cfg_data) > MAX_DESTINATIONS) ?
                         DcW'(MAX_DESTINATIONS) : DcW'(cfg_data);
        end
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        mme_pkg::S_DISPATCH: begin
          res_status <= mme_pkg::ST_OK;
          ptr        <= '0;
          unique case (cur_mode)
            mme_pkg::MODE_SET_SOURCE: begin
              if (!cur_src[SrcW]) begin
                res_status <= mme_pkg::ST_BAD_SOURCE;
              end else begin
                source_store[cur_src[SrcW-1:0]] <= cur_bad ? 16'sd0 : cur_value;
              end
            end
            mme_pkg::MODE_SET_BASE: begin
              if (slot_oob) begin
                res_status <= mme_pkg::ST_BAD_INDEX;
              end else begin
                base_store[cur_slot[DaW-1:0]] <= cur_value;
                base_bad[cur_slot[DaW-1:0]]   <= cur_bad;
              end
            end
            mme_pkg::MODE_LOAD_DEST: begin
              if (slot_oob) begin
                res_status <= mme_pkg::ST_BAD_INDEX;
              end else if (cur_min > cur_max) begin
                res_status <= mme_pkg::ST_BAD_DESC;
              end
            end
            mme_pkg::MODE_ADD_ROUTE: begin
              if (total_full) begin
                res_status <= mme_pkg::ST_BUDGET_FULL;
              end else if (!cur_src[SrcW] || cur_xf > mme_pkg::XF_BIPOLAR) begin
                res_status <= mme_pkg::ST_BAD_SOURCE;
              end else if (!depth_ok) begin
                res_status <= mme_pkg::ST_BAD_DEPTH;
              end else if (dest_bad) begin
                res_status <= mme_pkg::ST_BAD_DEST;
              end
            end
            mme_pkg::MODE_REMOVE_ROUTE: begin
              if (rm_bad) begin
                res_status <= mme_pkg::ST_BAD_INDEX;
              end else begin
                ptr <= CntW'(cur_slot) + 1'b1;
              end
            end
            mme_pkg::MODE_EVALUATE: begin
              touched <= '0;
            end
            default: ;
          endcase
        end
        mme_pkg::S_DUP_CMP: begin
          if (is_dup) begin
            res_status <= mme_pkg::ST_DUPLICATE;
          end else if (ptr + 1'b1 == route_total) begin
            ptr <= route_total;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        mme_pkg::S_SH_RD: begin
          if (ptr == '0) route_total <= route_total + 1'b1;
        end
        mme_pkg::S_SH_CMP: begin
          if (ordered) begin
            route_total <= route_total + 1'b1;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end
        mme_pkg::S_RM_RD: begin
          if (ptr_at_end) route_total <= route_total - 1'b1;
        end
        mme_pkg::S_RM_WR: begin
          ptr <= ptr + 1'b1;
        end
        mme_pkg::S_EV_RD: begin
          dptr <= '0;
        end
        mme_pkg::S_EV_ACC: begin
          if (!ev_skip) touched[ev_dest] <= 1'b1;
          ptr <= ptr + 1'b1;
        end
        mme_pkg::S_DST_SCAN: begin
          if (!dptr_end && !touched[didx]) dptr <= dptr + 1'b1;
        end
        mme_pkg::S_DST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            dptr      <= dptr + 1'b1;
          end
        end
        mme_pkg::S_RESPOND: begin
          if (out_free) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_mode  <= mode;
      cur_slot  <= slot;
      cur_kind  <= source_kind;
      cur_idx   <= source_index;
      cur_xf    <= transform;
      cur_value <= value;
      cur_bad   <= value_invalid;
      cur_min   <= dest_minimum;
      cur_max   <= dest_maximum;
      cur_step  <= dest_step;
      cur_type  <= dest_type;
    end

    if (state == mme_pkg::S_DISPATCH && cur_mode == mme_pkg::MODE_LOAD_DEST &&
        !slot_oob && !(cur_min > cur_max)) begin
      range_low_store[cur_slot[DaW-1:0]]  <= cur_min;
      range_high_store[cur_slot[DaW-1:0]] <= cur_max;
      step_store[cur_slot[DaW-1:0]]       <= cur_step;
      type_store[cur_slot[DaW-1:0]]       <= cur_type;
    end

    if (state == mme_pkg::S_EV_MUL) begin
      ev_skip <= 7'(rd_route.dest) >= 7'(dest_count);
      ev_dest <= rd_route.dest[DaW-1:0];
      ev_prod <= vb * rd_route.depth;
    end

    // a destination's sum restarts at its first touch
    if (state == mme_pkg::S_EV_ACC && !ev_skip) begin
      if (touched[ev_dest]) begin
        sum_store[ev_dest] <= sum_store[ev_dest] + 21'(rnd);
      end else begin
        sum_store[ev_dest] <= 21'(rnd);
      end
    end

    if (state == mme_pkg::S_DST_SCAN) norm <= norm_n;
    if (state == mme_pkg::S_DST_MUL) span_prod <= 47'(norm) * 47'(span);

    if (state == mme_pkg::S_DST_PLAIN) begin
      m_reg <= m_next;
      if (type_store[didx] == mme_pkg::DTYPE_BOOLEAN) begin
        plain_val <= (int'(norm) >= mme_pkg::Q14Half) ? d_hi : d_lo;
      end else begin
        plain_val <= plain_clamped;
      end
    end
    if (state == mme_pkg::S_DST_DIV && rem_done) plain_val <= plain_clamped;

    if (state == mme_pkg::S_DST_EMIT && out_free) begin
      status         <= mme_pkg::ST_OK;
      has_value      <= 1'b1;
      dest_index     <= 5'(dptr);
      normalized_out <= norm;
      plain_out      <= plain_val;
      last           <= !later_touched;
    end else if (state == mme_pkg::S_RESPOND && out_free) begin
      status         <= res_status;
      has_value      <= 1'b0;
      dest_index     <= '0;
      normalized_out <= '0;
      plain_out      <= '0;
      last           <= 1'b1;
    end
  end

  // ---------------- checks ----------------
  a_total_in_budget: assert property (@(posedge clk) disable iff (rst)
    CmpW'(route_total) <= CmpW'(budget))
    else $error("route count exceeds budget");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_value |-> last)
    else $error("status-only result without last");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_value |-> normalized_out <= 15'd16384)
    else $error("normalized value above one");

endmodule

`default_nettype wire
